@@ rtl/core/l2chs_pkg.sv @@
// ----------------------------------------------------------------------------
// l2chs_pkg
// Shared types, constants and divider step functions for the LBA to
// cylinder/head/sector conversion unit.
// ----------------------------------------------------------------------------
`default_nettype none

package l2chs_pkg;

   // Geometry limits and reset values.
   localparam logic [5:0]  SPT_RESET  = 6'd63;
   localparam logic [4:0]  HC_RESET   = 5'd16;
   localparam logic [31:0] CAP_RESET  = 32'd0;
   localparam logic [4:0]  HEAD_LIMIT = 5'd16;

   // Configuration register indexes.
   typedef enum logic [1:0] {
      CSR_SECTORS_PER_TRACK = 2'd0,
      CSR_HEAD_COUNT        = 2'd1,
      CSR_CAPACITY_SECTORS  = 2'd2
   } csr_index_type;

   // Divider pipeline shape: a fixed number of quotient bits per stage.
   localparam int DIVIDEND_W         = 32;
   localparam int DIV_BITS_PER_STAGE = 8;
   localparam int DIV1_STAGES        = DIVIDEND_W / DIV_BITS_PER_STAGE;
   localparam int DIV2_STAGES        = DIVIDEND_W / DIV_BITS_PER_STAGE;
   localparam int PIPE_DEPTH         = DIV1_STAGES + DIV2_STAGES;

   localparam int QUEUE_DEPTH = 4;
   localparam int OUT_DEPTH   = 16;

   typedef struct packed {
      logic [5:0]  sectors_per_track;
      logic [4:0]  head_count;
      logic [31:0] capacity_sectors;
   } cfg_type;

   // Item as classified by the front end.
   typedef struct packed {
      logic [31:0] lba;
      logic        range_err;
      logic        geo_err;
   } work_type;

   // Partial state of the division by sectors per track.
   typedef struct packed {
      logic [31:0] word;
      logic [5:0]  rem;
   } div1_type;

   // Partial state of the division by head count.
   typedef struct packed {
      logic [31:0] word;
      logic [4:0]  rem;
   } div2_type;

   typedef struct packed {
      logic       range_err;
      logic       geo_err;
      logic [5:0] sec_rem;
      div1_type   d1;
      div2_type   d2;
   } pipe_type;

   typedef struct packed {
      logic [5:0]  sector;
      logic [3:0]  head;
      logic [15:0] cylinder;
      logic        out_of_range;
   } result_type;

   // Restoring division, one stage worth of quotient bits. The dividend bits
   // leave the top of word while quotient bits enter at the bottom.
   function automatic div1_type div1_step(input div1_type cur, input logic [5:0] divisor);
      div1_type   st;
      logic [6:0] part;
      st = cur;
      for (int b = 0; b < DIV_BITS_PER_STAGE; b++) begin
         part = {st.rem, st.word[DIVIDEND_W-1]};
         if (part >= {1'b0, divisor}) begin
            st.rem  = 6'(part - {1'b0, divisor});
            st.word = {st.word[DIVIDEND_W-2:0], 1'b1};
         end else begin
            st.rem  = part[5:0];
            st.word = {st.word[DIVIDEND_W-2:0], 1'b0};
         end
      end
      return st;
   endfunction

   function automatic div2_type div2_step(input div2_type cur, input logic [4:0] divisor);
      div2_type   st;
      logic [5:0] part;
      st = cur;
      for (int b = 0; b < DIV_BITS_PER_STAGE; b++) begin
         part = {st.rem, st.word[DIVIDEND_W-1]};
         if (part >= {1'b0, divisor}) begin
            st.rem  = 5'(part - {1'b0, divisor});
            st.word = {st.word[DIVIDEND_W-2:0], 1'b1};
         end else begin
            st.rem  = part[4:0];
            st.word = {st.word[DIVIDEND_W-2:0], 1'b0};
         end
      end
      return st;
   endfunction

endpackage

`default_nettype wire

@@ rtl/core/l2chs_front.sv @@
// ----------------------------------------------------------------------------
// l2chs_front
// Input stage: takes request transfers, runs the capacity and geometry checks
// and holds the classified item until the work queue takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module l2chs_front
   import l2chs_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire cfg_type     cfg,
   input  wire logic        push,
   output logic             full,
   input  wire logic [31:0] req_lba,
   output logic             out_valid,
   output work_type         out_work,
   input  wire logic        out_ready
);

   logic     vld_ff, vld_in;
   work_type work_ff, work_in;
   logic     accept;

   assign full   = vld_ff && !out_ready;
   assign accept = push && !full;

   always_comb begin
      vld_in  = full ? vld_ff : push;
      work_in = work_ff;
      if (accept) begin
         work_in.lba       = req_lba;
         work_in.range_err = (req_lba >= cfg.capacity_sectors);
         work_in.geo_err   = (cfg.sectors_per_track == '0) || (cfg.head_count == '0) ||
                             (cfg.head_count > HEAD_LIMIT);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      work_ff <= work_in;
   end

   assign out_valid = vld_ff;
   assign out_work  = work_ff;

endmodule

`default_nettype wire

@@ rtl/core/l2chs_queue.sv @@
// ----------------------------------------------------------------------------
// l2chs_queue
// Short work queue between the front end and the divider pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

module l2chs_queue
   import l2chs_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     in_valid,
   input  wire work_type in_work,
   output logic          in_ready,
   output logic          out_valid,
   output work_type      out_work,
   input  wire logic     out_take
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   work_type           entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic               wr_en, rd_en;

   assign in_ready  = (cnt_ff != CNT_W'(QUEUE_DEPTH));
   assign out_valid = (cnt_ff != '0);
   assign out_work  = entry_ff[rd_ptr_ff];

   assign wr_en = in_valid && in_ready;
   assign rd_en = out_take && out_valid;

   always_comb begin
      wr_ptr_in = wr_en ? PTR_W'(wr_ptr_ff + 1'b1) : wr_ptr_ff;
      rd_ptr_in = rd_en ? PTR_W'(rd_ptr_ff + 1'b1) : rd_ptr_ff;
      cnt_in    = CNT_W'(cnt_ff + CNT_W'(wr_en) - CNT_W'(rd_en));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         entry_ff[wr_ptr_ff] <= in_work;
      end
   end

endmodule

`default_nettype wire

@@ rtl/core/l2chs_back.sv @@
// ----------------------------------------------------------------------------
// l2chs_back
// Back end: two pipelined restoring dividers (by sectors per track, then by
// head count) and the result queue that the response side reads.
// ----------------------------------------------------------------------------
`default_nettype none

module l2chs_back
   import l2chs_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire cfg_type  cfg,
   input  wire logic     q_valid,
   input  wire work_type q_work,
   output logic          q_take,
   output result_type    rsp,
   output logic          empty,
   input  wire logic     pop
);

   localparam int PTR_W = $clog2(OUT_DEPTH);
   localparam int OCC_W = $clog2(OUT_DEPTH + 1);

   pipe_type                issue_entry;
   pipe_type                pipe_in [PIPE_DEPTH];
   pipe_type                pipe_ff [PIPE_DEPTH];
   logic [PIPE_DEPTH-1:0]   vld_ff, vld_in;

   result_type              out_ff [OUT_DEPTH];
   result_type              res_new;
   logic [PTR_W-1:0]        wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]        rd_ptr_ff, rd_ptr_in;
   logic [OCC_W-1:0]        cnt_ff, cnt_in;
   logic [OCC_W-1:0]        occ_ff, occ_in;
   logic                    issue, wr_en, pop_fire;
   pipe_type                last;

   function automatic pipe_type stage_next(input pipe_type cur, input int idx,
                                           input logic [5:0] spt, input logic [4:0] hc);
      pipe_type nxt;
      nxt = cur;
      if (idx < DIV1_STAGES) begin
         nxt.d1 = div1_step(cur.d1, spt);
         // The first quotient is the track number, which feeds the second divider.
         if (idx == DIV1_STAGES - 1) begin
            nxt.sec_rem = nxt.d1.rem;
            nxt.d2.word = nxt.d1.word;
            nxt.d2.rem  = '0;
         end
      end else begin
         nxt.d2 = div2_step(cur.d2, hc);
      end
      return nxt;
   endfunction

   // Items in the pipeline plus items in the result queue never exceed the
   // queue depth, so the pipeline itself never has to stall.
   assign issue    = q_valid && (occ_ff != OCC_W'(OUT_DEPTH));
   assign q_take   = issue;
   assign pop_fire = pop && !empty;
   assign empty    = (cnt_ff == '0);
   assign wr_en    = vld_ff[PIPE_DEPTH-1];

   always_comb begin
      issue_entry           = '0;
      issue_entry.range_err = q_work.range_err;
      issue_entry.geo_err   = q_work.geo_err;
      issue_entry.d1.word   = q_work.lba;
   end

   assign pipe_in[0] = stage_next(issue_entry, 0, cfg.sectors_per_track, cfg.head_count);

   for (genvar g = 1; g < PIPE_DEPTH; g++) begin : g_stage
      assign pipe_in[g] = stage_next(pipe_ff[g-1], g, cfg.sectors_per_track,
                                     cfg.head_count);
   end

   assign vld_in = {vld_ff[PIPE_DEPTH-2:0], issue};
   assign last   = pipe_ff[PIPE_DEPTH-1];

   always_comb begin
      if (last.geo_err) begin
         res_new = '0;
         res_new.out_of_range = 1'b1;
      end else begin
         res_new.sector       = 6'(last.sec_rem + 6'd1);
         res_new.head         = last.d2.rem[3:0];
         res_new.cylinder     = last.d2.word[15:0];
         res_new.out_of_range = last.range_err || (last.d2.word[31:16] != '0);
      end
   end

   always_comb begin
      wr_ptr_in = wr_en ? PTR_W'(wr_ptr_ff + 1'b1) : wr_ptr_ff;
      rd_ptr_in = pop_fire ? PTR_W'(rd_ptr_ff + 1'b1) : rd_ptr_ff;
      cnt_in    = OCC_W'(cnt_ff + OCC_W'(wr_en) - OCC_W'(pop_fire));
      occ_in    = OCC_W'(occ_ff + OCC_W'(issue) - OCC_W'(pop_fire));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff    <= '0;
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
         occ_ff    <= '0;
      end else begin
         vld_ff    <= vld_in;
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
         occ_ff    <= occ_in;
      end
   end

   always_ff @(posedge clock) begin
      pipe_ff <= pipe_in;
      if (wr_en) begin
         out_ff[wr_ptr_ff] <= res_new;
      end
   end

   assign rsp = out_ff[rd_ptr_ff];

endmodule

`default_nettype wire

@@ rtl/core/lba_to_chs_with_range_check_unit.sv @@
// ----------------------------------------------------------------------------
// lba_to_chs_with_range_check_unit
// Converts a linear block address to cylinder, head and one-based sector for
// a configured disk geometry, and flags addresses out of range.
//
//   Channel    Ports                                  Transfer when
//   request    req_lba                                push && !full
//   response   rsp_sector, rsp_head, rsp_cylinder,    pop && !empty
//              rsp_out_of_range
//   config     csr_index, csr_wdata                   csr_we
//
// One address is taken per cycle and one result is given per cycle, sustained
// while the response side pops. From request transfer to the result showing, an
// item passes the input stage register, loaded at the transfer edge itself, the
// work queue, the eight divider stages (8 quotient bits each) and the result queue.
// A stalled response side fills the 16-entry result queue, then the work queue,
// then raises full; the two sides otherwise stall independently.
// Reset is synchronous and empties every queue; geometry returns to 63/16 and
// capacity to 0.
// ----------------------------------------------------------------------------
`default_nettype none

module lba_to_chs_with_range_check_unit
   import l2chs_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        push,
   output logic             full,
   input  wire logic [31:0] req_lba,
   output logic             empty,
   input  wire logic        pop,
   output logic [5:0]       rsp_sector,
   output logic [3:0]       rsp_head,
   output logic [15:0]      rsp_cylinder,
   output logic             rsp_out_of_range,
   input  wire logic        csr_we,
   input  wire logic [1:0]  csr_index,
   input  wire logic [31:0] csr_wdata
);

   cfg_type    cfg_ff, cfg_in;
   logic       fr_valid, q_ready;
   work_type   fr_work;
   logic       q_valid, q_take;
   work_type   q_work;
   result_type rsp;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_SECTORS_PER_TRACK: cfg_in.sectors_per_track = csr_wdata[5:0];
            CSR_HEAD_COUNT:        cfg_in.head_count        = csr_wdata[4:0];
            CSR_CAPACITY_SECTORS:  cfg_in.capacity_sectors  = csr_wdata;
            default:               cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.sectors_per_track <= SPT_RESET;
         cfg_ff.head_count        <= HC_RESET;
         cfg_ff.capacity_sectors  <= CAP_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   l2chs_front u_front (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .push      (push),
      .full      (full),
      .req_lba   (req_lba),
      .out_valid (fr_valid),
      .out_work  (fr_work),
      .out_ready (q_ready)
   );

   l2chs_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (fr_valid),
      .in_work   (fr_work),
      .in_ready  (q_ready),
      .out_valid (q_valid),
      .out_work  (q_work),
      .out_take  (q_take)
   );

   l2chs_back u_back (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg_ff),
      .q_valid (q_valid),
      .q_work  (q_work),
      .q_take  (q_take),
      .rsp     (rsp),
      .empty   (empty),
      .pop     (pop)
   );

   assign rsp_sector       = rsp.sector;
   assign rsp_head         = rsp.head;
   assign rsp_cylinder     = rsp.cylinder;
   assign rsp_out_of_range = rsp.out_of_range;

   // A result without the error flag always carries a one-based sector.
   a_sector_nonzero: assert property (@(posedge clock) disable iff (reset)
      !empty && !rsp_out_of_range |-> rsp_sector != '0)
      else $error("valid result carries sector zero");

   // Reset leaves both queue faces idle.
   a_reset_idle: assert property (@(posedge clock)
      reset |=> empty && !full)
      else $error("queues not empty after reset");

   // The front stage keeps its item until the work queue takes it.
   a_front_holds: assert property (@(posedge clock) disable iff (reset)
      fr_valid && !q_ready |=> fr_valid && $stable(fr_work))
      else $error("front item lost while work queue full");

endmodule

`default_nettype wire

@@ tb/sv/lba_to_chs_with_range_check_unit_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lba_to_chs_with_range_check_unit_tb
// Self-checking testbench for the LBA to cylinder/head/sector unit. Addresses
// go in through the request queue and their conversions are predicted from a
// local copy of the geometry. Each result popped from the response queue is
// compared field by field with the oldest prediction. Directed tests cover
// the capacity edge, cylinder overflow, invalid geometry and masked register
// writes. Random traffic follows under several idle and stall patterns.
// ----------------------------------------------------------------------------
module lba_to_chs_with_range_check_unit_tb;
   import l2chs_pkg::*;

   localparam logic [1:0] CSR_UNUSED_INDEX = 2'd3;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int DRAIN_CYCLES = 30;
   localparam int RANDOM_BATCH = 118;

   logic        clock     = 1'b0;
   logic        reset     = 1'b1;
   logic        push      = 1'b0;
   logic [31:0] req_lba   = '0;
   logic        pop       = 1'b0;
   logic        csr_we    = 1'b0;
   logic [1:0]  csr_index = '0;
   logic [31:0] csr_wdata = '0;
   logic        full;
   logic        empty;
   logic [5:0]  rsp_sector;
   logic [3:0]  rsp_head;
   logic [15:0] rsp_cylinder;
   logic        rsp_out_of_range;

   // Local copy of the geometry registers.
   logic [5:0]  geom_spt      = SPT_RESET;
   logic [4:0]  geom_heads    = HC_RESET;
   logic [31:0] geom_capacity = CAP_RESET;

   result_type  pending_chs[$];
   int          mismatch_count = 0;
   int          req_idle_pct   = 0;
   int          rsp_stall_pct  = 0;
   int          cycle_count    = 0;

   lba_to_chs_with_range_check_unit u_top (
      .clock            (clock),
      .reset            (reset),
      .push             (push),
      .full             (full),
      .req_lba          (req_lba),
      .empty            (empty),
      .pop              (pop),
      .rsp_sector       (rsp_sector),
      .rsp_head         (rsp_head),
      .rsp_cylinder     (rsp_cylinder),
      .rsp_out_of_range (rsp_out_of_range),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("lba_to_chs_with_range_check_unit_tb failed");
         $finish;
      end
   end

   function automatic result_type convert_lba(input logic [31:0] lba);
      result_type  r;
      logic [31:0] track;
      logic [31:0] cyl;
      r = '0;
      r.out_of_range = (lba >= geom_capacity);
      if (geom_spt == 6'd0 || geom_heads == 5'd0 || geom_heads > HEAD_LIMIT) begin
         r.out_of_range = 1'b1;
      end else begin
         track      = lba / geom_spt;
         r.sector   = 6'(lba % geom_spt + 32'd1);
         r.head     = 4'(track % geom_heads);
         cyl        = track / geom_heads;
         r.cylinder = cyl[15:0];
         if (cyl > 32'hFFFF) begin
            r.out_of_range = 1'b1;
         end
      end
      return r;
   endfunction

   // Writes all three registers and the unused index with write enable held
   // high, so that it is lowered only once at the end.
   task automatic set_geometry(input logic [31:0] spt_word, input logic [31:0] heads_word,
                               input logic [31:0] capacity);
      csr_we    <= 1'b1;
      csr_index <= CSR_SECTORS_PER_TRACK;
      csr_wdata <= spt_word;
      @(posedge clock);
      csr_index <= CSR_HEAD_COUNT;
      csr_wdata <= heads_word;
      @(posedge clock);
      csr_index <= CSR_CAPACITY_SECTORS;
      csr_wdata <= capacity;
      @(posedge clock);
      csr_index <= CSR_UNUSED_INDEX;
      csr_wdata <= $urandom;
      @(posedge clock);
      csr_we    <= 1'b0;
      geom_spt      = spt_word[5:0];
      geom_heads    = heads_word[4:0];
      geom_capacity = capacity;
   endtask

   task automatic send_lba(input logic [31:0] lba);
      while ($urandom_range(99) < req_idle_pct) begin
         push <= 1'b0;
         @(posedge clock);
      end
      push    <= 1'b1;
      req_lba <= lba;
      @(posedge clock);
      while (full) begin
         @(posedge clock);
      end
      pending_chs.push_back(convert_lba(lba));
   endtask

   task automatic wait_for_results();
      push <= 1'b0;
      while (pending_chs.size() != 0) begin
         @(posedge clock);
      end
   endtask

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         mismatch_count++;
      end
   endtask

   // The response side pops at random and checks every transfer.
   initial begin : rsp_checker
      result_type want;
      forever begin
         @(posedge clock);
         if (pop && !empty) begin
            if (pending_chs.size() == 0) begin
               $display("%0t: unexpected result, expected none, actual %0d/%0d/%0d/%0b",
                        $time, rsp_cylinder, rsp_head, rsp_sector, rsp_out_of_range);
               mismatch_count++;
            end else begin
               want = pending_chs.pop_front();
               check_field("sector", 32'(want.sector), 32'(rsp_sector));
               check_field("head", 32'(want.head), 32'(rsp_head));
               check_field("cylinder", 32'(want.cylinder), 32'(rsp_cylinder));
               check_field("out_of_range", 32'(want.out_of_range),
                           32'(rsp_out_of_range));
            end
         end
         pop <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   function automatic logic [31:0] pick_lba();
      longint span;
      span = longint'(geom_spt) * longint'(geom_heads) * 64'd65536;
      case ($urandom_range(3))
         0: return $urandom;
         1: return geom_capacity + $urandom_range(4) - 32'd2;
         2: begin
            if (span == 0) begin
               return $urandom;
            end
            return 32'(({$urandom, $urandom} & 64'h7FFF_FFFF_FFFF_FFFF) % span);
         end
         default: return $urandom_range(4095);
      endcase
   endfunction

   task automatic random_geometry();
      logic [31:0] spt;
      logic [31:0] heads;
      logic [31:0] capacity;
      spt   = $urandom_range(1, 63);
      heads = $urandom_range(1, 16);
      case ($urandom_range(11))
         0: spt = 0;
         1: heads = 0;
         2: heads = $urandom_range(17, 31);
         3: begin
            spt   = 1;
            heads = 1;
         end
         4: begin
            spt   = 63;
            heads = 16;
         end
         default: ;
      endcase
      case ($urandom_range(3))
         0: capacity = $urandom;
         1: capacity = 32'hFFFF_FFFF;
         2: capacity = 32'(spt * heads * $urandom_range(1, 65536));
         default: capacity = $urandom_range(1 << 20);
      endcase
      // Upper bits are junk that the register must drop.
      set_geometry(($urandom & ~32'h3F) | spt, ($urandom & ~32'h1F) | heads, capacity);
   endtask

   // Reset geometry has zero capacity, so everything is rejected.
   task automatic test_reset_geometry();
      send_lba(32'd0);
      send_lba(32'd1);
      send_lba(32'hFFFF_FFFF);
      wait_for_results();
   endtask

   task automatic test_field_extremes();
      set_geometry(32'd63, 32'd16, 32'hFFFF_FFFF);
      send_lba(32'd0);
      send_lba(32'd62);
      send_lba(32'd63);
      send_lba(32'd1007);
      send_lba(32'd1008);
      // Last address whose cylinder fits, then the first that overflows.
      send_lba(32'd66060287);
      send_lba(32'd66060288);
      send_lba(32'hFFFF_FFFF);
      wait_for_results();
      set_geometry(32'd1, 32'd1, 32'd65536);
      send_lba(32'd0);
      send_lba(32'd65535);
      send_lba(32'd65536);
      wait_for_results();
   endtask

   task automatic test_capacity_edge();
      set_geometry(32'd17, 32'd4, 32'd1000);
      send_lba(32'd999);
      send_lba(32'd1000);
      send_lba(32'd1001);
      wait_for_results();
   endtask

   // Invalid geometry, reached partly through write data that masks to zero
   // or to more than sixteen heads.
   task automatic test_invalid_geometry();
      set_geometry(32'hFFFF_FFC0, 32'd16, 32'hFFFF_FFFF);
      send_lba(32'd12345);
      wait_for_results();
      set_geometry(32'd63, 32'h00AB_CDE0, 32'hFFFF_FFFF);
      send_lba(32'd12345);
      wait_for_results();
      set_geometry(32'd63, 32'hFFFF_FFF1, 32'hFFFF_FFFF);
      send_lba(32'd12345);
      wait_for_results();
      set_geometry(32'd63, 32'd31, 32'hFFFF_FFFF);
      send_lba(32'd12345);
      wait_for_results();
      set_geometry(32'hFFFF_FFC5, 32'hFFFF_FFE3, 32'h8000_0000);
      send_lba(32'h7FFF_FFFF);
      wait_for_results();
   endtask

   task automatic test_random_traffic();
      int send_pct[4];
      int recv_pct[4];
      send_pct = '{0, 58, 0, 28};
      recv_pct = '{0, 0, 58, 28};
      for (int p = 0; p < 4; p++) begin
         for (int g = 0; g < 2; g++) begin
            wait_for_results();
            random_geometry();
            req_idle_pct  = send_pct[p];
            rsp_stall_pct = recv_pct[p];
            repeat (RANDOM_BATCH) begin
               send_lba(pick_lba());
            end
         end
      end
   endtask

   initial begin : stimulus
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      test_reset_geometry();
      test_field_extremes();
      test_capacity_edge();
      test_invalid_geometry();
      test_random_traffic();
      wait_for_results();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && pending_chs.size() == 0) begin
         $display("lba_to_chs_with_range_check_unit_tb passed");
      end else begin
         $display("lba_to_chs_with_range_check_unit_tb failed");
      end
      $finish;
   end

endmodule

@@ files.f @@
rtl/core/l2chs_pkg.sv
rtl/core/l2chs_front.sv
rtl/core/l2chs_queue.sv
rtl/core/l2chs_back.sv
rtl/core/lba_to_chs_with_range_check_unit.sv
tb/sv/lba_to_chs_with_range_check_unit_tb.sv
